### rtl/pbd_pkg.sv
// Package for the distance-constraint projection pipeline.
// Widths, item and sideband structs, outcome codes. No dependencies.
package pbd_pkg;

  localparam int PosBits   = 32;
  localparam int MassBits  = 16;
  localparam int MagBits   = PosBits + 1;       // |p2 - p1|
  localparam int SumSqBits = 2 * PosBits + 2;   // sum of three squares
  localparam int RootBits  = PosBits + 1;       // floor sqrt of the sum
  localparam int WsumBits  = MassBits + 1;
  localparam int DenBits   = RootBits + WsumBits;
  localparam int ProdBits  = MagBits + RootBits;
  localparam int NumBits   = ProdBits + MassBits + 1;
  localparam int QuoBits   = PosBits + 2;       // share never exceeds |D - L| + 1

  typedef logic signed [PosBits-1:0] pos_t;
  typedef logic [MassBits-1:0]       mass_t;
  typedef logic [MagBits-1:0]        mag_t;

  typedef enum logic [1:0] {
    OutCorrected  = 2'd0,
    OutPinned     = 2'd1,
    OutCoincident = 2'd2,
    OutSaturated  = 2'd3
  } outcome_e;

  typedef struct packed {
    pos_t                first_x;
    pos_t                first_y;
    pos_t                first_z;
    pos_t                second_x;
    pos_t                second_y;
    pos_t                second_z;
    mass_t               first_inv_mass;
    mass_t               second_inv_mass;
    logic [PosBits-2:0]  rest_length;
  } in_item_t;

  typedef struct packed {
    pos_t     new_first_x;
    pos_t     new_first_y;
    pos_t     new_first_z;
    pos_t     new_second_x;
    pos_t     new_second_y;
    pos_t     new_second_z;
    outcome_e outcome;
  } out_item_t;

  // Carried alongside the square root
  typedef struct packed {
    pos_t [2:0]         p1;
    pos_t [2:0]         p2;
    mag_t [2:0]         dmag;
    logic [2:0]         dneg;
    mass_t              w1;
    mass_t              w2;
    logic [PosBits-2:0] rest;
    logic               pinned;
    logic               coinc;
  } side_a_t;

  // Carried alongside the dividers
  typedef struct packed {
    pos_t [2:0] p1;
    pos_t [2:0] p2;
    logic [2:0] dneg;
    logic       drneg;
    logic       pinned;
    logic       coinc;
  } side_b_t;

endpackage

### rtl/pbd_sqrt_pipe.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Uses pbd_pkg for the default width; widths given by parameter.
module pbd_sqrt_pipe #(
  parameter int ROOT_W = pbd_pkg::RootBits
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [2*ROOT_W-1:0]   radicand_i,
  output logic                  valid_o,
  output logic [ROOT_W-1:0]     root_o
);

  localparam int RemW = ROOT_W + 3;

  logic [RemW-1:0]     rem_q  [ROOT_W];
  logic [ROOT_W-1:0]   root_q [ROOT_W];
  logic [2*ROOT_W-1:0] rad_q  [ROOT_W];
  logic [ROOT_W-1:0]   vld_q;

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [RemW-1:0]     rem_in, shifted, trial;
    logic [ROOT_W-1:0]   root_in;
    logic [2*ROOT_W-1:0] rad_in;
    logic                vld_in;

    if (s == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = radicand_i;
      assign vld_in  = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
      assign rad_in  = rad_q[s-1];
      assign vld_in  = vld_q[s-1];
    end

    // bring down two radicand bits, try (4r + 1)
    assign shifted = {rem_in[RemW-3:0], rad_in[2*ROOT_W-1 -: 2]};
    assign trial   = {1'b0, root_in, 2'b01};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[s] <= {rad_in[2*ROOT_W-3:0], 2'b00};
      if (shifted >= trial) begin
        rem_q[s]  <= shifted - trial;
        root_q[s] <= {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q[s]  <= shifted;
        root_q[s] <= {root_in[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign valid_o = vld_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];

endmodule

### rtl/pbd_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
// Uses pbd_pkg for the default widths; quotient must fit QUO_W bits.
module pbd_div_pipe #(
  parameter int NUM_W = pbd_pkg::NumBits,
  parameter int DEN_W = pbd_pkg::DenBits,
  parameter int QUO_W = pbd_pkg::QuoBits
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             valid_o,
  output logic [QUO_W-1:0] quo_o
);

  localparam int RemW = DEN_W + 1;

  logic [RemW-1:0]  rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];
  logic [QUO_W-1:0] lo_q  [QUO_W];
  logic [QUO_W-1:0] vld_q;

  for (genvar s = 0; s < QUO_W; s++) begin : g_stage
    logic [RemW-1:0]  rem_in, shifted;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in, lo_in;
    logic             vld_in;

    if (s == 0) begin : g_first
      assign rem_in = RemW'(num_i >> QUO_W);
      assign den_in = den_i;
      assign quo_in = '0;
      assign lo_in  = num_i[QUO_W-1:0];
      assign vld_in = valid_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
      assign lo_in  = lo_q[s-1];
      assign vld_in = vld_q[s-1];
    end

    assign shifted = {rem_in[RemW-2:0], lo_in[QUO_W-1]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s] <= 1'b0;
      end else begin
        vld_q[s] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      den_q[s] <= den_in;
      lo_q[s]  <= {lo_in[QUO_W-2:0], 1'b0};
      if (shifted >= {1'b0, den_in}) begin
        rem_q[s] <= shifted - {1'b0, den_in};
        quo_q[s] <= {quo_in[QUO_W-2:0], 1'b1};
      end else begin
        rem_q[s] <= shifted;
        quo_q[s] <= {quo_in[QUO_W-2:0], 1'b0};
      end
    end
  end

  assign valid_o = vld_q[QUO_W-1];
  assign quo_o   = quo_q[QUO_W-1];

endmodule

### rtl/pbd_delay.sv
// Fixed-depth delay line for sideband data riding next to a long unit.
// Standalone.
module pbd_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic [WIDTH-1:0] data_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] tap_q [DEPTH];

  always_ff @(posedge clk_i) begin
    tap_q[0] <= data_i;
    for (int i = 1; i < DEPTH; i++) begin
      tap_q[i] <= tap_q[i-1];
    end
  end

  assign data_o = tap_q[DEPTH-1];

endmodule

### rtl/pbd_distance_constraint_top.sv
// Top level of the distance-constraint projection pipeline.
// Uses pbd_pkg, pbd_sqrt_pipe, pbd_div_pipe and pbd_delay.

// One constraint enters per clock: busy_o stays low and start_i is taken in
// every cycle. Each item's result appears on out_item_o with out_valid_o high
// for one cycle, after passing through three front stages, the bit-per-stage
// square root, three multiply stages, the bit-per-stage dividers and the
// output stage. Results come in item order and must be taken when shown.
module pbd_distance_constraint_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  pbd_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  output pbd_pkg::out_item_t out_item_o
);

  localparam int P  = pbd_pkg::PosBits;
  localparam int SW = P + 3;   // position plus share before clamping

  // ---------------- stage 1: differences, pinned check
  pbd_pkg::side_a_t s1_d, s1_q;
  logic             v1_q;
  pbd_pkg::pos_t    in_p1 [3];
  pbd_pkg::pos_t    in_p2 [3];

  assign in_p1[0] = in_item_i.first_x;
  assign in_p1[1] = in_item_i.first_y;
  assign in_p1[2] = in_item_i.first_z;
  assign in_p2[0] = in_item_i.second_x;
  assign in_p2[1] = in_item_i.second_y;
  assign in_p2[2] = in_item_i.second_z;

  always_comb begin
    logic [P:0] diff;
    s1_d = '0;
    for (int a = 0; a < 3; a++) begin
      diff = {in_p2[a][P-1], in_p2[a]} - {in_p1[a][P-1], in_p1[a]};
      s1_d.p1[a]   = in_p1[a];
      s1_d.p2[a]   = in_p2[a];
      s1_d.dneg[a] = diff[P];
      s1_d.dmag[a] = diff[P] ? (~diff + 1'b1) : diff;
    end
    s1_d.w1     = in_item_i.first_inv_mass;
    s1_d.w2     = in_item_i.second_inv_mass;
    s1_d.rest   = in_item_i.rest_length;
    s1_d.pinned = (in_item_i.first_inv_mass == '0) && (in_item_i.second_inv_mass == '0);
    s1_d.coinc  = 1'b0;
  end

  // ---------------- stage 2: squares
  logic [2*pbd_pkg::MagBits-1:0] sq_d [3];
  logic [2*pbd_pkg::MagBits-1:0] sq_q [3];
  pbd_pkg::side_a_t              s2_q;
  logic                          v2_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sq_d[a] = s1_q.dmag[a] * s1_q.dmag[a];
    end
  end

  // ---------------- stage 3: sum of squares, coincident check
  logic [pbd_pkg::SumSqBits-1:0] ssum_d, ssum_q;
  pbd_pkg::side_a_t              s3_d, s3_q;
  logic                          v3_q;

  always_comb begin
    ssum_d = pbd_pkg::SumSqBits'(sq_q[0]) + pbd_pkg::SumSqBits'(sq_q[1])
           + pbd_pkg::SumSqBits'(sq_q[2]);
    s3_d       = s2_q;
    s3_d.coinc = (ssum_d == '0);
  end

  // ---------------- square root with sideband alongside
  logic                         root_vld;
  logic [pbd_pkg::RootBits-1:0] root;
  pbd_pkg::side_a_t             sa_out;

  pbd_sqrt_pipe #(
    .ROOT_W(pbd_pkg::RootBits)
  ) u_sqrt (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (v3_q),
    .radicand_i((2*pbd_pkg::RootBits)'(ssum_q)),
    .valid_o   (root_vld),
    .root_o    (root)
  );

  pbd_delay #(
    .WIDTH($bits(pbd_pkg::side_a_t)),
    .DEPTH(pbd_pkg::RootBits)
  ) u_side_a (
    .clk_i (clk_i),
    .data_i(s3_q),
    .data_o(sa_out)
  );

  // ---------------- stage 4: length error and denominator
  logic [pbd_pkg::RootBits-1:0] drmag_d, drmag_q;
  logic                         drneg_d, drneg4_q, drneg5_q;
  logic [pbd_pkg::DenBits-1:0]  den_d, den4_q, den5_q;
  pbd_pkg::side_a_t             s4_q, s5_q;
  logic                         v4_q, v5_q;

  always_comb begin
    logic [pbd_pkg::RootBits-1:0] rest_ext;
    logic [pbd_pkg::WsumBits-1:0] wsum;
    rest_ext = pbd_pkg::RootBits'(sa_out.rest);
    wsum     = pbd_pkg::WsumBits'(sa_out.w1) + pbd_pkg::WsumBits'(sa_out.w2);
    drneg_d  = root < rest_ext;
    drmag_d  = drneg_d ? (rest_ext - root) : (root - rest_ext);
    den_d    = root * wsum;
  end

  // ---------------- stage 5: |d_i| * |D - L|
  logic [pbd_pkg::ProdBits-1:0] prod_d [3];
  logic [pbd_pkg::ProdBits-1:0] prod_q [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      prod_d[a] = s4_q.dmag[a] * drmag_q;
    end
  end

  // ---------------- stage 6: weighted numerators with rounding term
  logic [pbd_pkg::NumBits-1:0] num_d [3][2];
  logic [pbd_pkg::NumBits-1:0] num_q [3][2];
  logic [pbd_pkg::DenBits-1:0] den6_q;
  pbd_pkg::side_b_t            sb_d, sb_q;
  logic                        v6_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      num_d[a][0] = pbd_pkg::NumBits'(prod_q[a]) * pbd_pkg::NumBits'(s5_q.w1)
                  + pbd_pkg::NumBits'(den5_q >> 1);
      num_d[a][1] = pbd_pkg::NumBits'(prod_q[a]) * pbd_pkg::NumBits'(s5_q.w2)
                  + pbd_pkg::NumBits'(den5_q >> 1);
    end
    sb_d.p1     = s5_q.p1;
    sb_d.p2     = s5_q.p2;
    sb_d.dneg   = s5_q.dneg;
    sb_d.drneg  = drneg5_q;
    sb_d.pinned = s5_q.pinned;
    sb_d.coinc  = s5_q.coinc;
  end

  // ---------------- six dividers with sideband alongside
  logic [pbd_pkg::QuoBits-1:0] quo [3][2];
  logic [5:0]                  div_vld;
  pbd_pkg::side_b_t            sb_out;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    for (genvar k = 0; k < 2; k++) begin : g_point
      pbd_div_pipe #(
        .NUM_W(pbd_pkg::NumBits),
        .DEN_W(pbd_pkg::DenBits),
        .QUO_W(pbd_pkg::QuoBits)
      ) u_div (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .valid_i(v6_q),
        .num_i  (num_q[a][k]),
        .den_i  (den6_q),
        .valid_o(div_vld[a*2+k]),
        .quo_o  (quo[a][k])
      );
    end
  end

  pbd_delay #(
    .WIDTH($bits(pbd_pkg::side_b_t)),
    .DEPTH(pbd_pkg::QuoBits)
  ) u_side_b (
    .clk_i (clk_i),
    .data_i(sb_q),
    .data_o(sb_out)
  );

  // ---------------- stage 7: apply shares, clamp, outcome
  pbd_pkg::out_item_t out_d, out_q;
  logic               v7_q;

  always_comb begin
    logic [SW-1:0] share1, share2, sum1, sum2;
    logic [P-1:0]  n1 [3];
    logic [P-1:0]  n2 [3];
    logic          sat, flip;
    sat = 1'b0;
    for (int a = 0; a < 3; a++) begin
      flip   = sb_out.dneg[a] ^ sb_out.drneg;
      share1 = SW'(quo[a][0]);
      share2 = SW'(quo[a][1]);
      if (flip) begin
        share1 = ~share1 + 1'b1;
        share2 = ~share2 + 1'b1;
      end
      sum1 = {{3{sb_out.p1[a][P-1]}}, sb_out.p1[a]} + share1;
      sum2 = {{3{sb_out.p2[a][P-1]}}, sb_out.p2[a]} - share2;
      // overflow when the bits above the sign disagree
      if ((&sum1[SW-1:P-1]) || !(|sum1[SW-1:P-1])) begin
        n1[a] = sum1[P-1:0];
      end else begin
        sat   = 1'b1;
        n1[a] = sum1[SW-1] ? {1'b1, {(P-1){1'b0}}} : {1'b0, {(P-1){1'b1}}};
      end
      if ((&sum2[SW-1:P-1]) || !(|sum2[SW-1:P-1])) begin
        n2[a] = sum2[P-1:0];
      end else begin
        sat   = 1'b1;
        n2[a] = sum2[SW-1] ? {1'b1, {(P-1){1'b0}}} : {1'b0, {(P-1){1'b1}}};
      end
    end

    if (sb_out.pinned || sb_out.coinc) begin
      out_d.new_first_x  = sb_out.p1[0];
      out_d.new_first_y  = sb_out.p1[1];
      out_d.new_first_z  = sb_out.p1[2];
      out_d.new_second_x = sb_out.p2[0];
      out_d.new_second_y = sb_out.p2[1];
      out_d.new_second_z = sb_out.p2[2];
      out_d.outcome      = sb_out.pinned ? pbd_pkg::OutPinned : pbd_pkg::OutCoincident;
    end else begin
      out_d.new_first_x  = n1[0];
      out_d.new_first_y  = n1[1];
      out_d.new_first_z  = n1[2];
      out_d.new_second_x = n2[0];
      out_d.new_second_y = n2[1];
      out_d.new_second_z = n2[2];
      out_d.outcome      = sat ? pbd_pkg::OutSaturated : pbd_pkg::OutCorrected;
    end
  end

  // ---------------- valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= root_vld;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= &div_vld;
    end
  end

  // ---------------- payload registers
  always_ff @(posedge clk_i) begin
    s1_q     <= s1_d;
    sq_q     <= sq_d;
    s2_q     <= s1_q;
    ssum_q   <= ssum_d;
    s3_q     <= s3_d;
    drmag_q  <= drmag_d;
    drneg4_q <= drneg_d;
    den4_q   <= den_d;
    s4_q     <= sa_out;
    prod_q   <= prod_d;
    drneg5_q <= drneg4_q;
    den5_q   <= den4_q;
    s5_q     <= s4_q;
    num_q    <= num_d;
    den6_q   <= den5_q;
    sb_q     <= sb_d;
    out_q    <= out_d;
  end

  assign busy_o      = 1'b0;
  assign out_valid_o = v7_q;
  assign out_item_o  = out_q;

endmodule
